FILE: hdl/skj_pkg.sv
`default_nettype none
package skj_pkg;

   localparam int unsigned NUM_ROUNDS = 32;
   localparam int unsigned KEY_BYTES  = 10;
   localparam int unsigned RND_W      = 5;

   localparam logic [0:0] OP_ENCRYPT = 1'b0;
   localparam logic [0:0] OP_DECRYPT = 1'b1;

   // CSR byte addresses (registers on 8-byte pitch, key_lower is 64 bits)
   localparam logic [3:0] CSR_KEY_UPPER = 4'h0;
   localparam logic [3:0] CSR_KEY_LOWER = 4'h8;

   // Data carried between round stages.
   typedef struct packed {
      logic        vld;
      logic        op;
      logic [63:0] blk;
   } stage_type;

   function automatic logic [7:0] ftab(input logic [7:0] x);
      logic [7:0] r;
      case (x)
         8'h00: r=8'ha3; 8'h01: r=8'hd7; 8'h02: r=8'h09; 8'h03: r=8'h83;
         8'h04: r=8'hf8; 8'h05: r=8'h48; 8'h06: r=8'hf6; 8'h07: r=8'hf4;
         8'h08: r=8'hb3; 8'h09: r=8'h21; 8'h0a: r=8'h15; 8'h0b: r=8'h78;
         8'h0c: r=8'h99; 8'h0d: r=8'hb1; 8'h0e: r=8'haf; 8'h0f: r=8'hf9;
         8'h10: r=8'he7; 8'h11: r=8'h2d; 8'h12: r=8'h4d; 8'h13: r=8'h8a;
         8'h14: r=8'hce; 8'h15: r=8'h4c; 8'h16: r=8'hca; 8'h17: r=8'h2e;
         8'h18: r=8'h52; 8'h19: r=8'h95; 8'h1a: r=8'hd9; 8'h1b: r=8'h1e;
         8'h1c: r=8'h4e; 8'h1d: r=8'h38; 8'h1e: r=8'h44; 8'h1f: r=8'h28;
         8'h20: r=8'h0a; 8'h21: r=8'hdf; 8'h22: r=8'h02; 8'h23: r=8'ha0;
         8'h24: r=8'h17; 8'h25: r=8'hf1; 8'h26: r=8'h60; 8'h27: r=8'h68;
         8'h28: r=8'h12; 8'h29: r=8'hb7; 8'h2a: r=8'h7a; 8'h2b: r=8'hc3;
         8'h2c: r=8'he9; 8'h2d: r=8'hfa; 8'h2e: r=8'h3d; 8'h2f: r=8'h53;
         8'h30: r=8'h96; 8'h31: r=8'h84; 8'h32: r=8'h6b; 8'h33: r=8'hba;
         8'h34: r=8'hf2; 8'h35: r=8'h63; 8'h36: r=8'h9a; 8'h37: r=8'h19;
         8'h38: r=8'h7c; 8'h39: r=8'hae; 8'h3a: r=8'he5; 8'h3b: r=8'hf5;
         8'h3c: r=8'hf7; 8'h3d: r=8'h16; 8'h3e: r=8'h6a; 8'h3f: r=8'ha2;
         8'h40: r=8'h39; 8'h41: r=8'hb6; 8'h42: r=8'h7b; 8'h43: r=8'h0f;
         8'h44: r=8'hc1; 8'h45: r=8'h93; 8'h46: r=8'h81; 8'h47: r=8'h1b;
         8'h48: r=8'hee; 8'h49: r=8'hb4; 8'h4a: r=8'h1a; 8'h4b: r=8'hea;
         8'h4c: r=8'hd0; 8'h4d: r=8'h91; 8'h4e: r=8'h2f; 8'h4f: r=8'hb8;
         8'h50: r=8'h55; 8'h51: r=8'hb9; 8'h52: r=8'hda; 8'h53: r=8'h85;
         8'h54: r=8'h3f; 8'h55: r=8'h41; 8'h56: r=8'hbf; 8'h57: r=8'he0;
         8'h58: r=8'h5a; 8'h59: r=8'h58; 8'h5a: r=8'h80; 8'h5b: r=8'h5f;
         8'h5c: r=8'h66; 8'h5d: r=8'h0b; 8'h5e: r=8'hd8; 8'h5f: r=8'h90;
         8'h60: r=8'h35; 8'h61: r=8'hd5; 8'h62: r=8'hc0; 8'h63: r=8'ha7;
         8'h64: r=8'h33; 8'h65: r=8'h06; 8'h66: r=8'h65; 8'h67: r=8'h69;
         8'h68: r=8'h45; 8'h69: r=8'h00; 8'h6a: r=8'h94; 8'h6b: r=8'h56;
         8'h6c: r=8'h6d; 8'h6d: r=8'h98; 8'h6e: r=8'h9b; 8'h6f: r=8'h76;
         8'h70: r=8'h97; 8'h71: r=8'hfc; 8'h72: r=8'hb2; 8'h73: r=8'hc2;
         8'h74: r=8'hb0; 8'h75: r=8'hfe; 8'h76: r=8'hdb; 8'h77: r=8'h20;
         8'h78: r=8'he1; 8'h79: r=8'heb; 8'h7a: r=8'hd6; 8'h7b: r=8'he4;
         8'h7c: r=8'hdd; 8'h7d: r=8'h47; 8'h7e: r=8'h4a; 8'h7f: r=8'h1d;
         8'h80: r=8'h42; 8'h81: r=8'hed; 8'h82: r=8'h9e; 8'h83: r=8'h6e;
         8'h84: r=8'h49; 8'h85: r=8'h3c; 8'h86: r=8'hcd; 8'h87: r=8'h43;
         8'h88: r=8'h27; 8'h89: r=8'hd2; 8'h8a: r=8'h07; 8'h8b: r=8'hd4;
         8'h8c: r=8'hde; 8'h8d: r=8'hc7; 8'h8e: r=8'h67; 8'h8f: r=8'h18;
         8'h90: r=8'h89; 8'h91: r=8'hcb; 8'h92: r=8'h30; 8'h93: r=8'h1f;
         8'h94: r=8'h8d; 8'h95: r=8'hc6; 8'h96: r=8'h8f; 8'h97: r=8'haa;
         8'h98: r=8'hc8; 8'h99: r=8'h74; 8'h9a: r=8'hdc; 8'h9b: r=8'hc9;
         8'h9c: r=8'h5d; 8'h9d: r=8'h5c; 8'h9e: r=8'h31; 8'h9f: r=8'ha4;
         8'ha0: r=8'h70; 8'ha1: r=8'h88; 8'ha2: r=8'h61; 8'ha3: r=8'h2c;
         8'ha4: r=8'h9f; 8'ha5: r=8'h0d; 8'ha6: r=8'h2b; 8'ha7: r=8'h87;
         8'ha8: r=8'h50; 8'ha9: r=8'h82; 8'haa: r=8'h54; 8'hab: r=8'h64;
         8'hac: r=8'h26; 8'had: r=8'h7d; 8'hae: r=8'h03; 8'haf: r=8'h40;
         8'hb0: r=8'h34; 8'hb1: r=8'h4b; 8'hb2: r=8'h1c; 8'hb3: r=8'h73;
         8'hb4: r=8'hd1; 8'hb5: r=8'hc4; 8'hb6: r=8'hfd; 8'hb7: r=8'h3b;
         8'hb8: r=8'hcc; 8'hb9: r=8'hfb; 8'hba: r=8'h7f; 8'hbb: r=8'hab;
         8'hbc: r=8'he6; 8'hbd: r=8'h3e; 8'hbe: r=8'h5b; 8'hbf: r=8'ha5;
         8'hc0: r=8'had; 8'hc1: r=8'h04; 8'hc2: r=8'h23; 8'hc3: r=8'h9c;
         8'hc4: r=8'h14; 8'hc5: r=8'h51; 8'hc6: r=8'h22; 8'hc7: r=8'hf0;
         8'hc8: r=8'h29; 8'hc9: r=8'h79; 8'hca: r=8'h71; 8'hcb: r=8'h7e;
         8'hcc: r=8'hff; 8'hcd: r=8'h8c; 8'hce: r=8'h0e; 8'hcf: r=8'he2;
         8'hd0: r=8'h0c; 8'hd1: r=8'hef; 8'hd2: r=8'hbc; 8'hd3: r=8'h72;
         8'hd4: r=8'h75; 8'hd5: r=8'h6f; 8'hd6: r=8'h37; 8'hd7: r=8'ha1;
         8'hd8: r=8'hec; 8'hd9: r=8'hd3; 8'hda: r=8'h8e; 8'hdb: r=8'h62;
         8'hdc: r=8'h8b; 8'hdd: r=8'h86; 8'hde: r=8'h10; 8'hdf: r=8'he8;
         8'he0: r=8'h08; 8'he1: r=8'h77; 8'he2: r=8'h11; 8'he3: r=8'hbe;
         8'he4: r=8'h92; 8'he5: r=8'h4f; 8'he6: r=8'h24; 8'he7: r=8'hc5;
         8'he8: r=8'h32; 8'he9: r=8'h36; 8'hea: r=8'h9d; 8'heb: r=8'hcf;
         8'hec: r=8'hf3; 8'hed: r=8'ha6; 8'hee: r=8'hbb; 8'hef: r=8'hac;
         8'hf0: r=8'h5e; 8'hf1: r=8'h6c; 8'hf2: r=8'ha9; 8'hf3: r=8'h13;
         8'hf4: r=8'h57; 8'hf5: r=8'h25; 8'hf6: r=8'hb5; 8'hf7: r=8'he3;
         8'hf8: r=8'hbd; 8'hf9: r=8'ha8; 8'hfa: r=8'h3a; 8'hfb: r=8'h01;
         8'hfc: r=8'h05; 8'hfd: r=8'h59; 8'hfe: r=8'h2a; 8'hff: r=8'h46;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/skj_round.sv
`default_nettype none
// One Skipjack round (encrypt or decrypt) followed by a stage register.
module skj_round
   import skj_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [RND_W-1:0]  enc_idx,   // zero-based round for encrypt
   input  wire logic [RND_W-1:0]  dec_idx,   // zero-based round for decrypt
   input  wire logic [79:0]       key,
   input  wire stage_type         stage_in,
   output stage_type              stage_out
);

   stage_type   stage_ff;
   stage_type   stage_next_in;
   logic [RND_W-1:0] idx;
   logic [15:0] rnum;
   logic [7:0]  kb [4];
   logic [15:0] w0, w1, w2, w3;
   logic [7:0]  a, b, c, d, e, f;
   logic [7:0]  dd, cc, bb, aa;
   logic        rule_b;

   always_comb begin
      logic [3:0] base;
      logic [4:0] n;
      idx = (stage_in.op == OP_DECRYPT) ? dec_idx : enc_idx;
      rnum = {11'd0, idx} + 16'd1;
      rule_b = idx[3];
      // first key byte of the round, (4*idx) mod 10, repeats every five rounds
      if (idx inside {5'd0, 5'd5, 5'd10, 5'd15, 5'd20, 5'd25, 5'd30}) begin
         base = 4'd0;
      end else if (idx inside {5'd1, 5'd6, 5'd11, 5'd16, 5'd21, 5'd26, 5'd31}) begin
         base = 4'd4;
      end else if (idx inside {5'd2, 5'd7, 5'd12, 5'd17, 5'd22, 5'd27}) begin
         base = 4'd8;
      end else if (idx inside {5'd3, 5'd8, 5'd13, 5'd18, 5'd23, 5'd28}) begin
         base = 4'd2;
      end else begin
         base = 4'd6;
      end
      for (int j = 0; j < 4; j++) begin
         n = {1'b0, base} + 5'(j);
         if (n >= 5'(KEY_BYTES)) begin
            n = n - 5'(KEY_BYTES);
         end
         kb[j] = key[79 - 8*n -: 8];
      end
   end

   assign w0 = stage_in.blk[63:48];
   assign w1 = stage_in.blk[47:32];
   assign w2 = stage_in.blk[31:16];
   assign w3 = stage_in.blk[15:0];

   // forward G on w0
   assign a = w0[15:8];
   assign b = w0[7:0];
   assign c = ftab(b ^ kb[0]) ^ a;
   assign d = ftab(c ^ kb[1]) ^ b;
   assign e = ftab(d ^ kb[2]) ^ c;
   assign f = ftab(e ^ kb[3]) ^ d;

   // inverse G on w1
   assign dd = ftab(w1[15:8] ^ kb[3]) ^ w1[7:0];
   assign cc = ftab(dd ^ kb[2]) ^ w1[15:8];
   assign bb = ftab(cc ^ kb[1]) ^ dd;
   assign aa = ftab(bb ^ kb[0]) ^ cc;

   always_comb begin
      logic [15:0] g;
      logic [15:0] gi;
      g  = {e, f};
      gi = {aa, bb};
      stage_next_in = stage_in;
      if (stage_in.op == OP_DECRYPT) begin
         if (!rule_b) begin
            stage_next_in.blk = {gi, w2, w3, w0 ^ w1 ^ rnum};
         end else begin
            stage_next_in.blk = {gi, gi ^ w2 ^ rnum, w3, w0};
         end
      end else begin
         if (!rule_b) begin
            stage_next_in.blk = {g ^ w3 ^ rnum, g, w1, w2};
         end else begin
            stage_next_in.blk = {w3, g, w0 ^ w1 ^ rnum, w2};
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.op  <= stage_next_in.op;
      stage_ff.blk <= stage_next_in.blk;
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else begin
         stage_ff.vld <= stage_next_in.vld;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

FILE: hdl/skipjack_block_cipher.sv
`default_nettype none
// Skipjack block cipher, 64-bit block, 80-bit key. Fully unrolled: 32 round
// stages, one register per round, so a block may be started every cycle
// (busy is always low) and its result appears on rsp_valid from the last of
// those stages, for one cycle. The receiver cannot stall the pipe, so it must
// take every result beat when rsp_valid is high. op 0 encrypts, 1 decrypts.
// Key: key_upper at byte address 0 (key bytes 0,1), key_lower at address 8
// (key bytes 2..9, byte 2 in the top bits). Change the key only when the
// pipe is empty: in-flight blocks use the live key in every stage.
module skipjack_block_cipher
   import skj_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_op,
   input  wire logic [63:0] req_block_in,
   output      logic        rsp_valid,
   output      logic [63:0] rsp_block_out,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [63:0] pwdata,
   output      logic [63:0] prdata,
   output      logic        pready
);

   logic [15:0] key_upper_ff;
   logic [63:0] key_lower_ff;
   logic        wr_en;
   stage_type   pipe [NUM_ROUNDS+1];

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (wr_en) begin
         if (paddr == CSR_KEY_UPPER) key_upper_ff <= pwdata[15:0];
         if (paddr == CSR_KEY_LOWER) key_lower_ff <= pwdata;
      end
   end

   always_comb begin
      case (paddr)
         CSR_KEY_UPPER: prdata = {48'd0, key_upper_ff};
         CSR_KEY_LOWER: prdata = key_lower_ff;
         default:       prdata = '0;
      endcase
   end

   assign pipe[0] = '{vld: start, op: req_op, blk: req_block_in};

   // Stage i does encrypt round i+1 or decrypt round 32-i.
   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_rnd
      skj_round u_round (
         .clock     (clock),
         .reset     (reset),
         .enc_idx   (RND_W'(i)),
         .dec_idx   (RND_W'(NUM_ROUNDS - 1 - i)),
         .key       ({key_upper_ff, key_lower_ff}),
         .stage_in  (pipe[i]),
         .stage_out (pipe[i+1])
      );
   end

   assign rsp_valid     = pipe[NUM_ROUNDS].vld;
   assign rsp_block_out = pipe[NUM_ROUNDS].blk;

   // A valid block in the first stage must reach rsp_valid at the end of the pipe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      pipe[1].vld |-> ##(NUM_ROUNDS-1) rsp_valid)
      else $error("result lost in pipe");
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy asserted");
   a_op_kept: assert property (@(posedge clock) disable iff (reset)
      pipe[1].vld |-> ##1 (pipe[2].op == $past(pipe[1].op)))
      else $error("op lost between stages");

endmodule
`default_nettype wire
